// File: rtl/mrle_pkg.sv
// mrle_pkg: shared types and constants for the maze run-length encoder
// request and response payload structs, result bundle, character codes
// no dependencies
package mrle_pkg;

   localparam int ROW_WIDTH_DEF = 32;
   localparam int MAX_ROWS_DEF  = 128;
   localparam int RUN_MAX_DEF   = 4095;

   localparam int SYMBOL_W    = 8;
   localparam int RUN_LEN_W   = 12;
   localparam int POS_COL_W   = 5;
   localparam int POS_ROW_W   = 7;
   localparam int MAX_RESULTS = 4;
   localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   localparam logic [SYMBOL_W-1:0] SYM_WALL  = 8'h2A;  // '*'
   localparam logic [SYMBOL_W-1:0] SYM_SPACE = 8'h20;  // ' '
   localparam logic [SYMBOL_W-1:0] SYM_START = 8'h53;  // 'S'
   localparam logic [SYMBOL_W-1:0] SYM_END   = 8'h45;  // 'E'
   localparam logic [SYMBOL_W-1:0] SYM_TRAP  = 8'h5E;  // '^'
   localparam logic [SYMBOL_W-1:0] SYM_COPY  = 8'h50;  // 'P'

   typedef enum logic [2:0] {
      KIND_WALL_RUN = 3'd0,
      KIND_OPEN_RUN = 3'd1,
      KIND_CHAR     = 3'd2,
      KIND_START    = 3'd3,
      KIND_END      = 3'd4
   } kind_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                final_req;
   } req_type;

   typedef struct packed {
      kind_type             kind;
      logic [RUN_LEN_W-1:0] run_length;
      logic [SYMBOL_W-1:0]  copied_char;
      logic [POS_COL_W-1:0] position_col;
      logic [POS_ROW_W-1:0] position_row;
      logic                 position_found;
      logic                 end_of_output;
   } rsp_type;

   // results caused by one request, packed from slot 0 upward
   typedef struct packed {
      logic [RES_CNT_W-1:0]         count;
      rsp_type [MAX_RESULTS-1:0]    res;
   } bundle_type;

endpackage

// File: rtl/mrle_core.sv
// mrle_core: coding state and per-request result generation
// holds run, copy mode and position state; builds the result bundle
// depends on mrle_pkg
module mrle_core import mrle_pkg::*; #(
   parameter int ROW_WIDTH = ROW_WIDTH_DEF,
   parameter int MAX_ROWS  = MAX_ROWS_DEF,
   parameter int RUN_MAX   = RUN_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  req_type    item,
   output bundle_type bundle
);

   localparam int COL_W = $clog2(ROW_WIDTH);
   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int CNT_W = $clog2(RUN_MAX + 1);
   localparam logic [CNT_W-1:0] RUN_MAX_C  = CNT_W'(RUN_MAX);
   localparam logic [COL_W-1:0] LAST_COL   = COL_W'(ROW_WIDTH - 1);
   localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(MAX_ROWS - 1);

   typedef enum logic [1:0] {
      CLS_NONE = 2'd0,
      CLS_WALL = 2'd1,
      CLS_OPEN = 2'd2
   } class_type;

   logic             copy_ff, copy_in;
   class_type        run_class_ff, run_class_in;
   logic [CNT_W-1:0] run_count_ff, run_count_in;
   logic [COL_W-1:0] cur_col_ff, cur_col_in;
   logic [ROW_W-1:0] cur_row_ff, cur_row_in;
   logic [COL_W-1:0] start_col_ff, start_col_in;
   logic [ROW_W-1:0] start_row_ff, start_row_in;
   logic             start_seen_ff, start_seen_in;
   logic [COL_W-1:0] goal_col_ff, goal_col_in;
   logic [ROW_W-1:0] goal_row_ff, goal_row_in;
   logic             goal_seen_ff, goal_seen_in;

   logic      is_s, is_e, is_p, is_wall, is_open;
   class_type sym_class;
   rsp_type [MAX_RESULTS-1:0] slot_res;
   logic    [MAX_RESULTS-1:0] slot_vld;
   logic    [RES_CNT_W-1:0]   pos;

   function automatic rsp_type make_run(class_type c, logic [CNT_W-1:0] n);
      rsp_type                        r;
      logic [CNT_W+RUN_LEN_W-1:0]     ext;
      r            = '0;
      ext          = {{RUN_LEN_W{1'b0}}, n};
      r.kind       = (c == CLS_WALL) ? KIND_WALL_RUN : KIND_OPEN_RUN;
      r.run_length = ext[RUN_LEN_W-1:0];
      return r;
   endfunction

   function automatic rsp_type make_pos(kind_type k, logic found,
                                        logic [COL_W-1:0] col,
                                        logic [ROW_W-1:0] row);
      rsp_type                        r;
      logic [COL_W+POS_COL_W-1:0]     col_ext;
      logic [ROW_W+POS_ROW_W-1:0]     row_ext;
      r                = '0;
      col_ext          = {{POS_COL_W{1'b0}}, col};
      row_ext          = {{POS_ROW_W{1'b0}}, row};
      r.kind           = k;
      r.position_found = found;
      r.position_col   = found ? col_ext[POS_COL_W-1:0] : '0;
      r.position_row   = found ? row_ext[POS_ROW_W-1:0] : '0;
      r.end_of_output  = (k == KIND_END);
      return r;
   endfunction

   assign is_s    = (item.symbol == SYM_START);
   assign is_e    = (item.symbol == SYM_END);
   assign is_p    = (item.symbol == SYM_COPY);
   assign is_wall = (item.symbol == SYM_WALL);
   assign is_open = (item.symbol == SYM_SPACE) || is_s || is_e || (item.symbol == SYM_TRAP);

   always_comb begin
      copy_in       = copy_ff;
      run_class_in  = run_class_ff;
      run_count_in  = run_count_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      start_col_in  = start_col_ff;
      start_row_in  = start_row_ff;
      start_seen_in = start_seen_ff;
      goal_col_in   = goal_col_ff;
      goal_row_in   = goal_row_ff;
      goal_seen_in  = goal_seen_ff;
      slot_vld      = '0;
      slot_res      = '0;
      sym_class     = is_wall ? CLS_WALL : (is_open ? CLS_OPEN : CLS_NONE);

      // markers use the position before this character advances it
      if (is_s) begin
         start_col_in  = cur_col_ff;
         start_row_in  = cur_row_ff;
         start_seen_in = 1'b1;
      end
      if (is_e) begin
         goal_col_in  = cur_col_ff;
         goal_row_in  = cur_row_ff;
         goal_seen_in = 1'b1;
      end

      // slot 0: run closed by this character
      if (!copy_ff && is_p) begin
         slot_vld[0]  = (run_class_ff != CLS_NONE) && (run_count_ff != '0);
         slot_res[0]  = make_run(run_class_ff, run_count_ff);
         run_class_in = CLS_NONE;
         run_count_in = '0;
         copy_in      = 1'b1;
      end else if (!copy_ff && sym_class != CLS_NONE) begin
         if (run_class_ff != sym_class) begin
            slot_vld[0]  = (run_class_ff != CLS_NONE) && (run_count_ff != '0);
            slot_res[0]  = make_run(run_class_ff, run_count_ff);
            run_class_in = sym_class;
            run_count_in = CNT_W'(1);
         end else if (run_count_ff >= RUN_MAX_C) begin
            // full run goes out, counting restarts
            slot_vld[0]  = 1'b1;
            slot_res[0]  = make_run(sym_class, RUN_MAX_C);
            run_count_in = CNT_W'(1);
         end else begin
            run_count_in = run_count_ff + CNT_W'(1);
         end
      end

      // slot 1: copied character, or the final flush of the pending run
      if (copy_in) begin
         slot_vld[1]             = 1'b1;
         slot_res[1].kind        = KIND_CHAR;
         slot_res[1].copied_char = item.symbol;
      end else if (item.final_req) begin
         slot_vld[1] = (run_class_in != CLS_NONE) && (run_count_in != '0);
         slot_res[1] = make_run(run_class_in, run_count_in);
      end

      slot_vld[2] = item.final_req;
      slot_res[2] = make_pos(KIND_START, start_seen_in, start_col_in, start_row_in);
      slot_vld[3] = item.final_req;
      slot_res[3] = make_pos(KIND_END, goal_seen_in, goal_col_in, goal_row_in);

      if (cur_col_ff == LAST_COL) begin
         cur_col_in = '0;
         if (cur_row_ff != LAST_ROW) begin
            cur_row_in = cur_row_ff + ROW_W'(1);
         end
      end else begin
         cur_col_in = cur_col_ff + COL_W'(1);
      end

      // end of maze: back to reset state for the next one
      if (item.final_req) begin
         copy_in       = 1'b0;
         run_class_in  = CLS_NONE;
         run_count_in  = '0;
         cur_col_in    = '0;
         cur_row_in    = '0;
         start_col_in  = '0;
         start_row_in  = '0;
         start_seen_in = 1'b0;
         goal_col_in   = '0;
         goal_row_in   = '0;
         goal_seen_in  = 1'b0;
      end
   end

   // pack valid slots toward slot 0
   always_comb begin
      bundle = '0;
      pos    = '0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (slot_vld[i]) begin
            bundle.res[pos[RES_IDX_W-1:0]] = slot_res[i];
            pos = pos + RES_CNT_W'(1);
         end
      end
      bundle.count = pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         copy_ff       <= 1'b0;
         run_class_ff  <= CLS_NONE;
         run_count_ff  <= '0;
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         start_col_ff  <= '0;
         start_row_ff  <= '0;
         start_seen_ff <= 1'b0;
         goal_col_ff   <= '0;
         goal_row_ff   <= '0;
         goal_seen_ff  <= 1'b0;
      end else if (advance) begin
         copy_ff       <= copy_in;
         run_class_ff  <= run_class_in;
         run_count_ff  <= run_count_in;
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         start_col_ff  <= start_col_in;
         start_row_ff  <= start_row_in;
         start_seen_ff <= start_seen_in;
         goal_col_ff   <= goal_col_in;
         goal_row_ff   <= goal_row_in;
         goal_seen_ff  <= goal_seen_in;
      end
   end

   a_copy_no_run: assert property (@(posedge clock) disable iff (reset)
      copy_ff |-> run_class_ff == CLS_NONE)
      else $error("run open while in copy mode");

   a_class_count: assert property (@(posedge clock) disable iff (reset)
      (run_class_ff == CLS_NONE) == (run_count_ff == '0))
      else $error("run class and run count disagree");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      cur_col_ff <= LAST_COL)
      else $error("column counter past row width");

endmodule

// File: rtl/mrle_out.sv
// mrle_out: response register holding one request's result bundle
// hands out the results one per response in slot order
// depends on mrle_pkg
module mrle_out import mrle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  bundle_type bundle_in,
   output logic       free,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   logic                 valid_ff;
   logic [RES_IDX_W-1:0] idx_ff;
   bundle_type           bundle_ff;
   logic                 last;

   assign last      = ({1'b0, idx_ff} + RES_CNT_W'(1)) == bundle_ff.count;
   assign free      = !valid_ff || (!rsp_stall && last);
   assign rsp_valid = valid_ff;
   assign rsp_data  = bundle_ff.res[idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (valid_ff && !rsp_stall) begin
         if (last) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + RES_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bundle_ff <= bundle_in;
      end
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> bundle_ff.count != '0 && ({1'b0, idx_ff} < bundle_ff.count))
      else $error("response index outside bundle");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("bundle overwritten before drained");

   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_stall && !last && !load |=>
         valid_ff && idx_ff == $past(idx_ff) + RES_IDX_W'(1))
      else $error("response index did not advance");

endmodule

// File: rtl/maze_run_length_encoder_unit.sv
// flow: a request waits in the input register until it fires; its results are then loaded
// into the response register and shown on rsp one per response, in slot order
// throughput: one request per cycle while rsp is not stalled and each causes at most one
// result; one with more (up to four) keeps the response register busy until all are taken
// reset: synchronous, clears the coding state, input register and response register
// top level: input register, coding core, response register; depends on mrle_pkg
module maze_run_length_encoder_unit import mrle_pkg::*; #(
   parameter int ROW_WIDTH = ROW_WIDTH_DEF,
   parameter int MAX_ROWS  = MAX_ROWS_DEF,
   parameter int RUN_MAX   = RUN_MAX_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic       item_valid_ff;
   req_type    item_ff;
   bundle_type bundle;
   logic       out_free;
   logic       fire;
   logic       load;

   // requests that cause no result move on even while the response is busy
   assign fire      = item_valid_ff && ((bundle.count == '0) || out_free);
   assign load      = fire && (bundle.count != '0);
   assign req_stall = item_valid_ff && !fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!item_valid_ff || fire) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_data;
      end
   end

   mrle_core #(
      .ROW_WIDTH (ROW_WIDTH),
      .MAX_ROWS  (MAX_ROWS),
      .RUN_MAX   (RUN_MAX)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (fire),
      .item    (item_ff),
      .bundle  (bundle)
   );

   mrle_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .bundle_in (bundle),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
